### hw/rtl/yuv_to_rgb_crop_converter_unit_defines.svh
// Assertion macros shared by the RTL of the YUV to RGB crop converter.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef YUV_TO_RGB_CROP_CONVERTER_UNIT_DEFINES_SVH
`define YUV_TO_RGB_CROP_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define YRC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define YRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/yrc_pkg.sv
// Package for the YUV to RGB crop converter: field widths, register codes,
// register reset values, video-range offsets and stage valid flags. No dependencies.
`default_nettype none

package yrc_pkg;

    localparam int COORD_W  = 11;
    localparam int SAMPLE_W = 8;
    localparam int COMP_W   = 8;
    localparam int DIM_W    = 12;
    localparam int SIDE_W   = 10;
    localparam int VMARG_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_SIDE_MARGIN   = 3'd2,
        REG_TOP_MARGIN    = 3'd3,
        REG_BOTTOM_MARGIN = 3'd4,
        REG_BLUE_FIRST    = 3'd5
    } cfg_reg_t;

    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH   = 12'd1164;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT  = 12'd874;
    localparam logic [SIDE_W-1:0]  RST_SIDE_MARGIN   = 10'd175;
    localparam logic [VMARG_W-1:0] RST_TOP_MARGIN    = 11'd0;
    localparam logic [VMARG_W-1:0] RST_BOTTOM_MARGIN = 11'd209;
    localparam logic               RST_BLUE_FIRST    = 1'b1;

    // Video-range offsets for luma and chroma.
    localparam logic [SAMPLE_W:0] LUMA_OFFSET   = 9'd16;
    localparam logic [SAMPLE_W:0] CHROMA_OFFSET = 9'd128;

    // Stage valid flags handed between pipeline stages.
    typedef struct packed {
        logic v1;
        logic v2;
        logic v3;
    } stage_valid_t;

endpackage

`default_nettype wire

### hw/rtl/yuv_to_rgb_crop_converter_unit.sv
// Top level of the YUV to RGB crop converter: crop test, BT.601 conversion
// and component ordering. Depends on yrc_pkg and the assertion macro header.
//
//  Channel | Ports                                   | Handshake
//  --------+-----------------------------------------+-------------------------
//  input   | s_luma s_chroma_blue s_chroma_red ...   | s_valid / s_ready
//  result  | m_first_component m_green_component ... | m_valid / m_ready
//  config  | cfg_index cfg_wdata                     | cfg_we, no wait
//
// One pixel per cycle is accepted while s_ready is high; a kept pixel passes
// four register stages (input compare, multiply, sum, shift and clamp), the
// last of which drives m_valid and the result.
// Pixels outside the crop window leave no result; they pass on as empty slots.
// Each stage holds while the stage after it is full and stalled, so s_ready
// falls only when every stage holds a pixel and m_ready is low.
// Reset clears the valid flags and loads the register reset values.
`default_nettype none
`include "yuv_to_rgb_crop_converter_unit_defines.svh"

module yuv_to_rgb_crop_converter_unit #(
    parameter int COEF_FRAC_BITS = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [yrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [yrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [yrc_pkg::SAMPLE_W-1:0]  s_luma,
    input  wire logic [yrc_pkg::SAMPLE_W-1:0]  s_chroma_blue,
    input  wire logic [yrc_pkg::SAMPLE_W-1:0]  s_chroma_red,
    input  wire logic [yrc_pkg::COORD_W-1:0]   s_column,
    input  wire logic [yrc_pkg::COORD_W-1:0]   s_row,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [yrc_pkg::COMP_W-1:0]         m_first_component,
    output logic [yrc_pkg::COMP_W-1:0]         m_green_component,
    output logic [yrc_pkg::COMP_W-1:0]         m_third_component
);
    import yrc_pkg::*;

    // Coefficients rounded to nearest at COEF_FRAC_BITS fraction bits.
    localparam int K_Y_INT  = ((1164 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_RV_INT = ((1596 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_GV_INT = ((813 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_GU_INT = ((391 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_BU_INT = ((2018 << COEF_FRAC_BITS) + 500) / 1000;

    // Three-term sums stay below 2^(COEF_FRAC_BITS+11) in magnitude.
    localparam int PW  = COEF_FRAC_BITS + 12;
    localparam int QW  = PW - COEF_FRAC_BITS;
    localparam int EDW = DIM_W + 1;

    localparam logic signed [PW-1:0] K_Y  = PW'(K_Y_INT);
    localparam logic signed [PW-1:0] K_RV = PW'(K_RV_INT);
    localparam logic signed [PW-1:0] K_GV = PW'(K_GV_INT);
    localparam logic signed [PW-1:0] K_GU = PW'(K_GU_INT);
    localparam logic signed [PW-1:0] K_BU = PW'(K_BU_INT);

    // Configuration registers.
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [SIDE_W-1:0]  side_margin_reg;
    logic [VMARG_W-1:0] top_margin_reg;
    logic [VMARG_W-1:0] bottom_margin_reg;
    logic               blue_first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            side_margin_reg   <= RST_SIDE_MARGIN;
            top_margin_reg    <= RST_TOP_MARGIN;
            bottom_margin_reg <= RST_BOTTOM_MARGIN;
            blue_first_reg    <= RST_BLUE_FIRST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[DIM_W-1:0];
                REG_SIDE_MARGIN:   side_margin_reg   <= cfg_wdata[SIDE_W-1:0];
                REG_TOP_MARGIN:    top_margin_reg    <= cfg_wdata[VMARG_W-1:0];
                REG_BOTTOM_MARGIN: bottom_margin_reg <= cfg_wdata[VMARG_W-1:0];
                REG_BLUE_FIRST:    blue_first_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Stage flow control: a stage loads when it is empty or drains this cycle.
    stage_valid_t vld;
    logic         rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !m_valid || m_ready;
    assign rdy3    = !vld.v3 || rdy4;
    assign rdy2    = !vld.v2 || rdy3;
    assign rdy1    = !vld.v1 || rdy2;
    assign s_ready = rdy1;

    // Stage 1: crop test and offset removal.
    logic signed [EDW-1:0]      right_edge, bottom_edge;
    logic                       keep_next;
    logic signed [SAMPLE_W:0]   dy_next, du_next, dv_next;
    logic signed [SAMPLE_W:0]   dy_reg, du_reg, dv_reg;
    logic                       v1_reg;

    always_comb begin
        right_edge  = $signed({1'b0, frame_width_reg}) - $signed(EDW'(side_margin_reg));
        bottom_edge = $signed({1'b0, frame_height_reg}) - $signed(EDW'(bottom_margin_reg));
        keep_next   = (s_column >= COORD_W'(side_margin_reg))
                   && ($signed(EDW'(s_column)) < right_edge)
                   && (s_row >= top_margin_reg)
                   && ($signed(EDW'(s_row)) < bottom_edge);
        dy_next = $signed({1'b0, s_luma}) - $signed(LUMA_OFFSET);
        du_next = $signed({1'b0, s_chroma_blue}) - $signed(CHROMA_OFFSET);
        dv_next = $signed({1'b0, s_chroma_red}) - $signed(CHROMA_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_valid && keep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            dy_reg <= dy_next;
            du_reg <= du_next;
            dv_reg <= dv_next;
        end
    end

    // Stage 2: constant multiplications.
    logic signed [PW-1:0] py_next, prv_next, pgv_next, pgu_next, pbu_next;
    logic signed [PW-1:0] py_reg, prv_reg, pgv_reg, pgu_reg, pbu_reg;
    logic                 v2_reg;

    always_comb begin
        py_next  = K_Y  * PW'(dy_reg);
        prv_next = K_RV * PW'(dv_reg);
        pgv_next = K_GV * PW'(dv_reg);
        pgu_next = K_GU * PW'(du_reg);
        pbu_next = K_BU * PW'(du_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            py_reg  <= py_next;
            prv_reg <= prv_next;
            pgv_reg <= pgv_next;
            pgu_reg <= pgu_next;
            pbu_reg <= pbu_next;
        end
    end

    // Stage 3: component sums.
    logic signed [PW-1:0] r_sum_next, g_sum_next, b_sum_next;
    logic signed [PW-1:0] r_sum_reg, g_sum_reg, b_sum_reg;
    logic                 v3_reg;

    always_comb begin
        r_sum_next = py_reg + prv_reg;
        g_sum_next = py_reg - pgv_reg - pgu_reg;
        b_sum_next = py_reg + pbu_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
        end
    end

    assign vld.v1 = v1_reg;
    assign vld.v2 = v2_reg;
    assign vld.v3 = v3_reg;

    // Stage 4: floor shift, clamp, ordering into the output register.
    function automatic logic [COMP_W-1:0] clamp_comp(input logic signed [PW-1:0] sum);
        logic signed [QW-1:0] q;
        q = QW'(sum >>> COEF_FRAC_BITS);
        if (q < 0) begin
            return '0;
        end else if (q > $signed(QW'(255))) begin
            return '1;
        end else begin
            return q[COMP_W-1:0];
        end
    endfunction

    logic [COMP_W-1:0] r_comp, g_comp, b_comp;
    logic [COMP_W-1:0] first_next, third_next;
    logic              m_valid_reg;
    logic [COMP_W-1:0] first_reg, green_reg, third_reg;

    always_comb begin
        r_comp     = clamp_comp(r_sum_reg);
        g_comp     = clamp_comp(g_sum_reg);
        b_comp     = clamp_comp(b_sum_reg);
        first_next = blue_first_reg ? b_comp : r_comp;
        third_next = blue_first_reg ? r_comp : b_comp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy4) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            first_reg <= first_next;
            green_reg <= g_comp;
            third_reg <= third_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_first_component = first_reg;
    assign m_green_component = green_reg;
    assign m_third_component = third_reg;

    // The input side stalls only when the output holds a result nobody takes.
    `YRC_ASSERT_SAME(a_ready_only_on_stall, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output backpressure")
    // A pixel in the sum stage always reaches the output register.
    `YRC_ASSERT_NEXT(a_sum_reaches_output, aclk, aresetn, v3_reg && rdy4, m_valid, "pixel lost between sum stage and output")
    // A stalled multiply stage keeps its pixel.
    `YRC_ASSERT_NEXT(a_mult_stage_holds, aclk, aresetn, v2_reg && !rdy3, v2_reg, "multiply stage dropped a stalled pixel")

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for yuv_to_rgb_crop_converter_unit: directed pixels, then
// random pixels over several crop windows, checked against a local predictor.
// Depends on yrc_pkg and the RTL of the converter.

module testbench;
    import yrc_pkg::*;

    localparam int FRAC_BITS    = 10;
    localparam int K_LUMA       = 1192;
    localparam int K_RED_V      = 1634;
    localparam int K_GREEN_V    = 833;
    localparam int K_GREEN_U    = 400;
    localparam int K_BLUE_U     = 2066;
    localparam int SETTLE       = 10;
    localparam int PHASE_ITEMS  = 160;
    localparam int EMPTY_ITEMS  = 40;
    localparam int NUM_PHASES   = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] chroma_blue;
        logic [SAMPLE_W-1:0] chroma_red;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
    } pixel_t;

    typedef struct packed {
        logic [COMP_W-1:0] first;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] third;
    } rgb_t;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [SIDE_W-1:0]  side_margin;
        logic [VMARG_W-1:0] top_margin;
        logic [VMARG_W-1:0] bottom_margin;
        logic               blue_first;
    } window_cfg_t;

    typedef enum logic [1:0] {
        CHECK_PREDICTED,
        CHECK_DROPPED,
        CHECK_TYPED
    } row_check_t;

    typedef struct packed {
        pixel_t     px;
        row_check_t mode;
        rgb_t       rgb;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_luma;
    logic [SAMPLE_W-1:0]   s_chroma_blue;
    logic [SAMPLE_W-1:0]   s_chroma_red;
    logic [COORD_W-1:0]    s_column;
    logic [COORD_W-1:0]    s_row;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COMP_W-1:0]     m_first_component;
    logic [COMP_W-1:0]     m_green_component;
    logic [COMP_W-1:0]     m_third_component;

    window_cfg_t crop;
    rgb_t        expected_rgb[$];
    stim_row_t   directed_rows[$];
    int          errors = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    yuv_to_rgb_crop_converter_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_luma            (s_luma),
        .s_chroma_blue     (s_chroma_blue),
        .s_chroma_red      (s_chroma_red),
        .s_column          (s_column),
        .s_row             (s_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_first_component (m_first_component),
        .m_green_component (m_green_component),
        .m_third_component (m_third_component)
    );

    always #1 aclk = ~aclk;

    // The fixed-point sum is floored by an arithmetic shift, then clamped.
    function automatic logic [COMP_W-1:0] clamp_component(input int sum);
        int q;
        q = sum >>> FRAC_BITS;
        if (q < 0) return '0;
        if (q > 255) return 8'd255;
        return q[COMP_W-1:0];
    endfunction

    function automatic bit convert_pixel(input pixel_t px, output rgb_t res);
        int col, row, right, bottom, c, du, dv;
        logic [COMP_W-1:0] red, grn, blu;
        col    = int'(px.column);
        row    = int'(px.row);
        right  = int'(crop.frame_width) - int'(crop.side_margin);
        bottom = int'(crop.frame_height) - int'(crop.bottom_margin);
        res    = '0;
        if (col < int'(crop.side_margin) || col >= right) return 1'b0;
        if (row < int'(crop.top_margin) || row >= bottom) return 1'b0;
        c   = K_LUMA * (int'(px.luma) - 16);
        du  = int'(px.chroma_blue) - 128;
        dv  = int'(px.chroma_red) - 128;
        red = clamp_component(c + K_RED_V * dv);
        grn = clamp_component(c - K_GREEN_V * dv - K_GREEN_U * du);
        blu = clamp_component(c + K_BLUE_U * du);
        res.first = crop.blue_first ? blu : red;
        res.green = grn;
        res.third = crop.blue_first ? red : blu;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly inside the window, with its edges and the first pixel past them.
    function automatic logic [COORD_W-1:0] pick_coord(input int lo, input int hi);
        int hi_c, sel;
        hi_c = (hi > 2048) ? 2048 : hi;
        sel  = $urandom_range(0, 9);
        if (lo < hi_c && lo < 2048) begin
            if (sel == 0) return COORD_W'(lo);
            if (sel == 1) return COORD_W'(hi_c - 1);
            if (sel < 8) return COORD_W'($urandom_range(lo, hi_c - 1));
        end
        if (sel == 8) begin
            if ($urandom_range(0, 1) == 0 && lo > 0 && lo <= 2048) return COORD_W'(lo - 1);
            if (hi >= 0 && hi < 2048) return COORD_W'(hi);
        end
        return COORD_W'($urandom_range(0, 2047));
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.luma        = pick_sample();
        px.chroma_blue = pick_sample();
        px.chroma_red  = pick_sample();
        px.column      = pick_coord(int'(crop.side_margin),
                                    int'(crop.frame_width) - int'(crop.side_margin));
        px.row         = pick_coord(int'(crop.top_margin),
                                    int'(crop.frame_height) - int'(crop.bottom_margin));
        return px;
    endfunction

    function automatic void queue_row(input stim_row_t entry);
        directed_rows.insert(directed_rows.size(), entry);
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_FRAME_WIDTH:   crop.frame_width   = data[DIM_W-1:0];
            REG_FRAME_HEIGHT:  crop.frame_height  = data[DIM_W-1:0];
            REG_SIDE_MARGIN:   crop.side_margin   = data[SIDE_W-1:0];
            REG_TOP_MARGIN:    crop.top_margin    = data[VMARG_W-1:0];
            REG_BOTTOM_MARGIN: crop.bottom_margin = data[VMARG_W-1:0];
            REG_BLUE_FIRST:    crop.blue_first    = data[0];
            default: ;
        endcase
    endtask

    // Writes to the two unused indexes must leave the window untouched.
    task automatic load_window(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                               input logic [CFG_DATA_W-1:0] sm, input logic [CFG_DATA_W-1:0] tm,
                               input logic [CFG_DATA_W-1:0] bm, input logic [CFG_DATA_W-1:0] bf);
        cfg_write(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 4095)));
        cfg_write(REG_FRAME_WIDTH, fw);
        cfg_write(REG_FRAME_HEIGHT, fh);
        cfg_write(REG_SIDE_MARGIN, sm);
        cfg_write(REG_TOP_MARGIN, tm);
        cfg_write(REG_BOTTOM_MARGIN, bm);
        cfg_write(REG_BLUE_FIRST, bf);
        cfg_write(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 4095)));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input pixel_t px);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_luma        <= px.luma;
        s_chroma_blue <= px.chroma_blue;
        s_chroma_red  <= px.chroma_red;
        s_column      <= px.column;
        s_row         <= px.row;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_predicted(input pixel_t px);
        rgb_t res;
        send_pixel(px);
        if (convert_pixel(px, res)) expected_rgb.insert(expected_rgb.size(), res);
    endtask

    // Dropped pixels leave nothing to wait for, so the pipeline gets extra cycles.
    task automatic wait_drained();
        while (expected_rgb.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        rgb_t exp_rgb;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rgb.size() == 0) begin
                $error("unexpected result transaction: %0d %0d %0d",
                       m_first_component, m_green_component, m_third_component);
                errors++;
            end else begin
                exp_rgb = expected_rgb.pop_front();
                if (m_first_component !== exp_rgb.first) begin
                    $error("first_component: expected %0d, actual %0d",
                           exp_rgb.first, m_first_component);
                    errors++;
                end
                if (m_green_component !== exp_rgb.green) begin
                    $error("green_component: expected %0d, actual %0d",
                           exp_rgb.green, m_green_component);
                    errors++;
                end
                if (m_third_component !== exp_rgb.third) begin
                    $error("third_component: expected %0d, actual %0d",
                           exp_rgb.third, m_third_component);
                    errors++;
                end
            end
        end
    end

    initial begin
        int n_items;
        int fw;
        int fh;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_luma        = '0;
        s_chroma_blue = '0;
        s_chroma_red  = '0;
        s_column      = '0;
        s_row         = '0;
        crop = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_SIDE_MARGIN,
                 RST_TOP_MARGIN, RST_BOTTOM_MARGIN, RST_BLUE_FIRST};

        // Reset window: columns 175..988, rows 0..664, blue first.
        queue_row('{'{8'd16, 8'd128, 8'd128, 11'd175, 11'd0},
                    CHECK_TYPED, '{8'd0, 8'd0, 8'd0}});
        queue_row('{'{8'd255, 8'd128, 8'd128, 11'd988, 11'd664},
                    CHECK_TYPED, '{8'd255, 8'd255, 8'd255}});
        queue_row('{'{8'd0, 8'd128, 8'd128, 11'd500, 11'd300},
                    CHECK_TYPED, '{8'd0, 8'd0, 8'd0}});
        queue_row('{'{8'd235, 8'd128, 8'd128, 11'd600, 11'd10},
                    CHECK_TYPED, '{8'd254, 8'd254, 8'd254}});
        queue_row('{'{8'd200, 8'd50, 8'd60, 11'd174, 11'd0},
                    CHECK_DROPPED, '0});
        queue_row('{'{8'd200, 8'd50, 8'd60, 11'd989, 11'd0},
                    CHECK_DROPPED, '0});
        queue_row('{'{8'd200, 8'd50, 8'd60, 11'd500, 11'd665},
                    CHECK_DROPPED, '0});
        queue_row('{'{8'd255, 8'd255, 8'd255, 11'd0, 11'd0},
                    CHECK_DROPPED, '0});
        queue_row('{'{8'd255, 8'd255, 8'd255, 11'd2047, 11'd2047},
                    CHECK_DROPPED, '0});
        queue_row('{'{8'd0, 8'd0, 8'd0, 11'd1024, 11'd1024},
                    CHECK_DROPPED, '0});
        queue_row('{'{8'd255, 8'd255, 8'd255, 11'd175, 11'd664},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd0, 8'd0, 8'd0, 11'd988, 11'd0},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd255, 8'd0, 8'd255, 11'd400, 11'd200},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd0, 8'd255, 8'd0, 11'd401, 11'd201},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd128, 8'd0, 8'd0, 11'd511, 11'd511},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd128, 8'd255, 8'd255, 11'd512, 11'd512},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd170, 8'd85, 8'd170, 11'd682, 11'd341},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd85, 8'd170, 8'd85, 11'd341, 11'd170},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd16, 8'd255, 8'd0, 11'd700, 11'd600},
                    CHECK_PREDICTED, '0});
        queue_row('{'{8'd235, 8'd0, 8'd255, 11'd256, 11'd128},
                    CHECK_PREDICTED, '0});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode == CHECK_PREDICTED) begin
                send_predicted(directed_rows[i].px);
            end else begin
                send_pixel(directed_rows[i].px);
                if (directed_rows[i].mode == CHECK_TYPED)
                    expected_rgb.insert(expected_rgb.size(), directed_rows[i].rgb);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // The sender holds off here until every result is back.
            s_valid <= 1'b0;
            wait_drained();
            n_items = PHASE_ITEMS;
            case (phase)
                0: load_window(12'd2048, 12'd2048, 12'd0, 12'd0, 12'd0, 12'd0);
                1: load_window(12'd2048, 12'd2048, 12'd1023, 12'd2047, 12'd0, 12'hFFF);
                2: load_window(12'd1, 12'd1, 12'd0, 12'd0, 12'd0, 12'd0);
                3: begin
                    // Margins wider than the frame leave an empty window.
                    load_window(12'd100, 12'd5, 12'hFFF, 12'd0, 12'hFFF, 12'd1);
                    n_items = EMPTY_ITEMS;
                end
                4: load_window(12'hFFF, 12'hFFF, 12'd500, 12'd1000, 12'd3000, 12'hFFE);
                default: begin
                    fw = $urandom_range(1, 2048);
                    fh = $urandom_range(1, 2048);
                    load_window(CFG_DATA_W'(fw), CFG_DATA_W'(fh),
                                CFG_DATA_W'($urandom_range(0, (fw / 2 > 1023) ? 1023 : fw / 2)),
                                CFG_DATA_W'($urandom_range(0, fh / 2)),
                                CFG_DATA_W'($urandom_range(0, fh / 2)),
                                CFG_DATA_W'($urandom_range(0, 4095)));
                end
            endcase
            quiet = (phase == NUM_PHASES - 1);
            for (int i = 0; i < n_items; i++) send_predicted(random_pixel());
        end

        s_valid <= 1'b0;
        wait_drained();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/yrc_pkg.sv
hw/rtl/yuv_to_rgb_crop_converter_unit.sv
bench/testbench.sv
